// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the ray box face hit block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define RBFH_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// condition must never be seen outside reset
`define RBFH_ASSERT_NEVER(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("forbidden condition seen");

`endif

// ===== rtl/rbfh_pkg.sv =====
// ----------------------------------------------------------------------------
// rbfh_pkg
// types and constants shared by the ray box face hit modules
// ----------------------------------------------------------------------------
`default_nettype none

package rbfh_pkg;

  localparam int CoordW = 32;
  localparam int DistW  = 31;
  localparam int TolW   = 16;
  localparam int CfgAw  = 3;
  localparam int DivSteps = 32;
  localparam int NumFaces = 6;

  localparam logic [DistW-1:0] DistMax = {DistW{1'b1}};

  typedef enum logic [CfgAw-1:0] {
    CFG_MIN_X = 3'd0,
    CFG_MIN_Y = 3'd1,
    CFG_MIN_Z = 3'd2,
    CFG_MAX_X = 3'd3,
    CFG_MAX_Y = 3'd4,
    CFG_MAX_Z = 3'd5,
    CFG_TOL   = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic              ok;
    logic              ovf;
    logic [CoordW-1:0] quo;
  } div_res_t;

  typedef struct packed {
    logic [2:0][CoordW-1:0] origin;
    logic [2:0][CoordW-1:0] dir;
    logic [DistW-1:0]       best;
  } side_t;

endpackage

`default_nettype wire

// ===== rtl/rbfh_div.sv =====
// ----------------------------------------------------------------------------
// rbfh_div
// pipelined face distance divider, one quotient bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module rbfh_div import rbfh_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                     clk_i,
  input  wire logic signed [CoordW-1:0] corner_i,
  input  wire logic signed [CoordW-1:0] origin_i,
  input  wire logic signed [CoordW-1:0] dir_i,
  output div_res_t                      res_o
);

  localparam int NW = CoordW + 1 + FRAC_BITS;
  localparam int HW = NW - CoordW;

  logic [CoordW:0]   diff;
  logic [NW-1:0]     num;
  logic [NW-1:0]     abs_num;
  logic [CoordW-1:0] abs_d;
  logic [HW-1:0]     hi;

  assign diff    = {corner_i[CoordW-1], corner_i} - {origin_i[CoordW-1], origin_i};
  assign num     = {diff, {FRAC_BITS{1'b0}}};
  assign abs_num = num[NW-1] ? (~num + NW'(1)) : num;
  assign abs_d   = dir_i[CoordW-1] ? (~dir_i + CoordW'(1)) : dir_i;
  assign hi      = abs_num[NW-1:CoordW];

  logic [CoordW:0]   rem_q [DivSteps+1];
  logic [CoordW-1:0] nq_q  [DivSteps+1];
  logic [CoordW-1:0] d_q   [DivSteps+1];
  logic              ok_q  [DivSteps+1];
  logic              ovf_q [DivSteps+1];

  always_ff @(posedge clk_i) begin
    rem_q[0] <= (CoordW+1)'(hi);
    nq_q[0]  <= abs_num[CoordW-1:0];
    d_q[0]   <= abs_d;
    ok_q[0]  <= (dir_i != '0) && (num[NW-1] == dir_i[CoordW-1]);
    ovf_q[0] <= {{(CoordW-HW){1'b0}}, hi} >= abs_d;
  end

  for (genvar k = 0; k < DivSteps; k++) begin : g_step
    logic [CoordW:0] rem_sh;
    logic            ge;
    assign rem_sh = {rem_q[k][CoordW-1:0], nq_q[k][CoordW-1]};
    assign ge     = rem_sh >= {1'b0, d_q[k]};
    always_ff @(posedge clk_i) begin
      rem_q[k+1] <= ge ? (rem_sh - {1'b0, d_q[k]}) : rem_sh;
      nq_q[k+1]  <= {nq_q[k][CoordW-2:0], ge};
      d_q[k+1]   <= d_q[k];
      ok_q[k+1]  <= ok_q[k];
      ovf_q[k+1] <= ovf_q[k];
    end
  end

  assign res_o.ok  = ok_q[DivSteps];
  assign res_o.ovf = ovf_q[DivSteps];
  assign res_o.quo = nq_q[DivSteps];

endmodule

`default_nettype wire

// ===== rtl/rbfh_face_check.sv =====
// ----------------------------------------------------------------------------
// rbfh_face_check
// hit point and widened containment test for one face, two stages
// ----------------------------------------------------------------------------
`default_nettype none

module rbfh_face_check import rbfh_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          tv_i,
  input  wire logic [DistW-1:0]              t_i,
  input  wire logic [2:0][CoordW-1:0]        origin_i,
  input  wire logic [2:0][CoordW-1:0]        dir_i,
  input  wire logic [DistW-1:0]              best_i,
  input  wire logic [2:0][CoordW-1:0]        lo_i,
  input  wire logic [2:0][CoordW-1:0]        hi_i,
  input  wire logic [TolW-1:0]               tol_i,
  output logic                               ok_o,
  output logic [DistW-1:0]                   t_o
);

  localparam int PW = 2 * CoordW;

  logic signed [PW-1:0]     prod_q [3];
  logic [2:0][CoordW-1:0]   org_q;
  logic [DistW-1:0]         t_q;
  logic [DistW-1:0]         best_q;
  logic                     tv_q;

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      prod_q[a] <= $signed({{(PW-DistW){1'b0}}, t_i}) *
                   $signed({{CoordW{dir_i[a][CoordW-1]}}, dir_i[a]});
    end
    org_q  <= origin_i;
    t_q    <= t_i;
    best_q <= best_i;
    tv_q   <= tv_i;
  end

  logic [2:0] in_box;

  always_comb begin
    logic signed [PW-1:0] p;
    logic signed [PW-1:0] lo_w;
    logic signed [PW-1:0] hi_w;
    for (int a = 0; a < 3; a++) begin
      p    = $signed({{CoordW{org_q[a][CoordW-1]}}, org_q[a]}) + (prod_q[a] >>> FRAC_BITS);
      lo_w = $signed({{CoordW{lo_i[a][CoordW-1]}}, lo_i[a]}) - $signed(PW'(tol_i));
      hi_w = $signed({{CoordW{hi_i[a][CoordW-1]}}, hi_i[a]}) + $signed(PW'(tol_i));
      in_box[a] = (p > lo_w) && (p < hi_w);
    end
  end

  always_ff @(posedge clk_i) begin
    ok_o <= tv_q && (&in_box) && (t_q < best_q);
    t_o  <= t_q;
  end

endmodule

`default_nettype wire

// ===== rtl/ray_box_face_hit.sv =====
// ----------------------------------------------------------------------------
// ray_box_face_hit
// ray against an axis-aligned box, nearest strictly closer face hit
// ----------------------------------------------------------------------------
// One ray is taken on every cycle that start_i is high; busy_o stays low.
// The result is driven for one cycle with done_o high and is taken in that
// cycle: the block has no way to hold it. The path runs through the six face
// dividers, an input register followed by 32 stages that produce one quotient
// bit each, then a saturation stage, a multiply stage, a containment stage
// and the registered nearest-face select. Box and tolerance registers are
// read live, so write them only while no ray is in flight.
`default_nettype none

module ray_box_face_hit import rbfh_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [CfgAw-1:0]         cfg_addr_i,
  input  wire logic [CoordW-1:0]        cfg_wdata_i,
  input  wire logic                     start_i,
  output logic                          busy_o,
  input  wire logic signed [CoordW-1:0] origin_x_i,
  input  wire logic signed [CoordW-1:0] origin_y_i,
  input  wire logic signed [CoordW-1:0] origin_z_i,
  input  wire logic signed [CoordW-1:0] dir_x_i,
  input  wire logic signed [CoordW-1:0] dir_y_i,
  input  wire logic signed [CoordW-1:0] dir_z_i,
  input  wire logic [DistW-1:0]         best_distance_i,
  output logic                          done_o,
  output logic                          hit_o,
  output logic [DistW-1:0]              new_distance_o
);

  `include "assert_macros.svh"

  localparam int SideLen = DivSteps + 4;
  localparam int Lat     = SideLen + 1;

  logic [2:0][CoordW-1:0] lo_q;
  logic [2:0][CoordW-1:0] hi_q;
  logic [TolW-1:0]        tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q  <= '0;
      hi_q  <= '0;
      tol_q <= TolW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_MIN_X: lo_q[0] <= cfg_wdata_i;
        CFG_MIN_Y: lo_q[1] <= cfg_wdata_i;
        CFG_MIN_Z: lo_q[2] <= cfg_wdata_i;
        CFG_MAX_X: hi_q[0] <= cfg_wdata_i;
        CFG_MAX_Y: hi_q[1] <= cfg_wdata_i;
        CFG_MAX_Z: hi_q[2] <= cfg_wdata_i;
        CFG_TOL:   tol_q   <= cfg_wdata_i[TolW-1:0];
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  logic                   xfer;
  logic [2:0][CoordW-1:0] org_in;
  logic [2:0][CoordW-1:0] dir_in;

  assign xfer   = start_i && !busy_o;
  assign org_in = {origin_z_i, origin_y_i, origin_x_i};
  assign dir_in = {dir_z_i, dir_y_i, dir_x_i};

  // side data and valid bits travel alongside the dividers
  side_t side_q  [SideLen];
  logic  valid_q [SideLen];

  always_ff @(posedge clk_i) begin
    side_q[0] <= '{origin: org_in, dir: dir_in, best: best_distance_i};
    for (int j = 1; j < SideLen; j++) begin
      side_q[j] <= side_q[j-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < SideLen; j++) begin
        valid_q[j] <= 1'b0;
      end
    end else begin
      valid_q[0] <= xfer;
      for (int j = 1; j < SideLen; j++) begin
        valid_q[j] <= valid_q[j-1];
      end
    end
  end

  div_res_t         div_res [NumFaces];
  logic             tv_q    [NumFaces];
  logic [DistW-1:0] t_q     [NumFaces];
  logic             ok      [NumFaces];
  logic [DistW-1:0] t_f     [NumFaces];

  for (genvar f = 0; f < NumFaces; f++) begin : g_face
    localparam int Ax = f % 3;

    rbfh_div #(
      .FRAC_BITS (FRAC_BITS)
    ) u_div (
      .clk_i    (clk_i),
      .corner_i ((f < 3) ? lo_q[Ax] : hi_q[Ax]),
      .origin_i (org_in[Ax]),
      .dir_i    (dir_in[Ax]),
      .res_o    (div_res[f])
    );

    // saturate and keep strictly positive distances
    always_ff @(posedge clk_i) begin
      tv_q[f] <= div_res[f].ok && (div_res[f].ovf || (div_res[f].quo != '0));
      if (div_res[f].ovf || div_res[f].quo[CoordW-1]) begin
        t_q[f] <= DistMax;
      end else begin
        t_q[f] <= div_res[f].quo[DistW-1:0];
      end
    end

    rbfh_face_check #(
      .FRAC_BITS (FRAC_BITS)
    ) u_check (
      .clk_i    (clk_i),
      .tv_i     (tv_q[f]),
      .t_i      (t_q[f]),
      .origin_i (side_q[DivSteps+1].origin),
      .dir_i    (side_q[DivSteps+1].dir),
      .best_i   (side_q[DivSteps+1].best),
      .lo_i     (lo_q),
      .hi_i     (hi_q),
      .tol_i    (tol_q),
      .ok_o     (ok[f]),
      .t_o      (t_f[f])
    );
  end

  logic             hit_d;
  logic [DistW-1:0] dist_d;

  always_comb begin
    hit_d  = 1'b0;
    dist_d = side_q[SideLen-1].best;
    for (int f = 0; f < NumFaces; f++) begin
      if (ok[f] && (t_f[f] < dist_d)) begin
        dist_d = t_f[f];
        hit_d  = 1'b1;
      end
    end
  end

  logic             done_q;
  logic             hit_q;
  logic [DistW-1:0] dist_q;
  logic [DistW-1:0] best_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_q[SideLen-1];
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q       <= hit_d;
    dist_q      <= dist_d;
    best_last_q <= side_q[SideLen-1].best;
  end

  assign done_o         = done_q;
  assign hit_o          = hit_q;
  assign new_distance_o = dist_q;

  `RBFH_ASSERT(a_latency, clk_i, rst_ni, xfer |-> ##Lat done_o)
  `RBFH_ASSERT(a_no_ghost, clk_i, rst_ni, done_o |-> $past(xfer, Lat))
  `RBFH_ASSERT_NEVER(a_hit_closer, clk_i, rst_ni, done_o && hit_o && (new_distance_o >= best_last_q))
  `RBFH_ASSERT_NEVER(a_miss_keeps, clk_i, rst_ni, done_o && !hit_o && (new_distance_o != best_last_q))

endmodule

`default_nettype wire
